// File: rtl/nfew_pkg.sv
// ----------------------------------------------------------------------------
// nfew_pkg
// Types, register indexes, sequencer states and constants shared by the NRZ
// first-order edge waveform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nfew_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW = 3;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 32;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Exponential working format is Q1.30, and 1.0 itself must be representable.
  localparam int unsigned WorkW   = 31;
  localparam logic [WorkW-1:0] WorkOne = 31'h4000_0000;

  localparam logic [3:0] HornerTerms = 4'd12;
  localparam logic [1:0] SquareLast  = 2'd3;

  localparam int unsigned TimeW   = 33;
  localparam int unsigned OffsetW = 33;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_PERIOD = 3'd0,
    CFG_ZERO_LEVEL = 3'd1,
    CFG_ONE_LEVEL  = 3'd2,
    CFG_ZERO_RATE  = 3'd3,
    CFG_ONE_RATE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] step_time_ps;
    logic        next_bit;
  } in_item_t;

  typedef struct packed {
    logic [31:0] power_nw;
    logic        bit_now;
  } out_item_t;

  typedef struct packed {
    logic [31:0] bit_period_ps;
    logic [31:0] zero_level_nw;
    logic [31:0] one_level_nw;
    logic [23:0] zero_rate;
    logic [23:0] one_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_XCHK,
    ST_H_MUL,
    ST_H_DIV,
    ST_H_FIX,
    ST_SQ_MUL,
    ST_SQ_RND,
    ST_EXP_RND,
    ST_SET_MUL,
    ST_SET_ADD
  } state_e;

  // floor((2^32 - 1) / div). A product with this value, shifted down by 32,
  // underestimates the true quotient by at most one.
  function automatic logic [31:0] recip_lookup(logic [3:0] div);
    logic [31:0] res;
    case (div)
      4'd1:    res = 32'hFFFF_FFFF;
      4'd2:    res = 32'h7FFF_FFFF;
      4'd3:    res = 32'h5555_5555;
      4'd4:    res = 32'h3FFF_FFFF;
      4'd5:    res = 32'h3333_3333;
      4'd6:    res = 32'h2AAA_AAAA;
      4'd7:    res = 32'h2492_4924;
      4'd8:    res = 32'h1FFF_FFFF;
      4'd9:    res = 32'h1C71_C71C;
      4'd10:   res = 32'h1999_9999;
      4'd11:   res = 32'h1745_D174;
      4'd12:   res = 32'h1555_5555;
      default: res = 32'h0000_0000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nfew_cfg_regs.sv
// ----------------------------------------------------------------------------
// nfew_cfg_regs
// Configuration register file: period, steady levels and rates.
// ----------------------------------------------------------------------------
`default_nettype none

module nfew_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nfew_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output nfew_pkg::cfg_t               cfg_o
);
  import nfew_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period_ps <= 32'd1000;
      cfg_q.zero_level_nw <= 32'd0;
      cfg_q.one_level_nw  <= 32'd1000000;
      cfg_q.zero_rate     <= 24'd16777;
      cfg_q.one_rate      <= 24'd16777;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BIT_PERIOD: cfg_q.bit_period_ps <= cfg_data_i;
        CFG_ZERO_LEVEL: cfg_q.zero_level_nw <= cfg_data_i;
        CFG_ONE_LEVEL:  cfg_q.one_level_nw  <= cfg_data_i;
        CFG_ZERO_RATE:  cfg_q.zero_rate     <= cfg_data_i[23:0];
        CFG_ONE_RATE:   cfg_q.one_rate      <= cfg_data_i[23:0];
        default: begin
          // Unmapped indexes are ignored.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/nfew_mul.sv
// ----------------------------------------------------------------------------
// nfew_mul
// Shared unsigned multiplier with a registered product, used for the wide
// products of the waveform computation.
// ----------------------------------------------------------------------------
`default_nettype none

module nfew_mul (
  input  logic                       clk_i,
  input  logic [nfew_pkg::MulAW-1:0] a_i,
  input  logic [nfew_pkg::MulBW-1:0] b_i,
  output logic [nfew_pkg::MulPW-1:0] p_o
);
  import nfew_pkg::*;

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/nrz_first_order_edge_waveform_unit.sv
// Each exponential runs 12 Horner steps and 4 squarings, plus setup and
// settling, and skips the steps and squarings when its argument is 16 or more.
// A tick that crosses a bit boundary evaluates two exponentials on the single
// shared multiplier. A new input is taken in the cycle after the result is
// registered. Reset restores the register defaults and clears time and offset.
// ----------------------------------------------------------------------------
// nrz_first_order_edge_waveform_unit
// NRZ optical power generator with first-order rise and fall edges, built
// around one multiplier that a small sequencer reuses for every wide product.
// ----------------------------------------------------------------------------
`default_nettype none

module nrz_first_order_edge_waveform_unit #(
  parameter int unsigned EXP_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  nfew_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output nfew_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nfew_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import nfew_pkg::*;

  localparam int unsigned EW     = EXP_FRAC_BITS + 1;
  localparam int unsigned ShiftE = 30 - EXP_FRAC_BITS;

  cfg_t cfg;

  nfew_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;

  nfew_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  state_e state_q, state_d;

  logic [TimeW-1:0]          t_q, t_d;
  logic signed [OffsetW-1:0] offset_q, offset_d;
  logic                      cur_bit_q, cur_bit_d;
  logic                      nbit_q, nbit_d;
  logic                      first_q, first_d;
  logic                      bnd_q, bnd_d;
  logic [29:0]               u_q, u_d;
  logic [WorkW-1:0]          r_q, r_d;
  logic [29:0]               d_q, d_d;
  logic [3:0]                i_q, i_d;
  logic [1:0]                sq_q, sq_d;
  logic [EW-1:0]             e_q, e_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_item_q, out_item_d;

  logic [23:0]       rate_cur;
  logic [31:0]       target_cur;
  logic [31:0]       target_new;
  logic [TimeW:0]    t_sum;
  logic [TimeW-1:0]  t_sat;
  logic              crossed;
  logic [OffsetW-1:0] off_neg;
  logic [31:0]       mag;
  logic [29:0]       q_est;
  logic [33:0]       rem_w;
  logic [29:0]       quot;
  logic [31:0]       r_round;
  logic [MulPW-1:0]  p_round;
  logic [32:0]       qv;
  logic signed [34:0] level_raw;
  logic [31:0]       level;

  assign rate_cur   = cur_bit_q ? cfg.one_rate : cfg.zero_rate;
  assign target_cur = cur_bit_q ? cfg.one_level_nw : cfg.zero_level_nw;
  assign target_new = nbit_q ? cfg.one_level_nw : cfg.zero_level_nw;

  // Elapsed time saturates at the top of its 33-bit range.
  assign t_sum   = (TimeW + 1)'(t_q) + (TimeW + 1)'(in_item_i.step_time_ps);
  assign t_sat   = t_sum[TimeW] ? {TimeW{1'b1}} : t_sum[TimeW-1:0];
  assign crossed = t_q >= TimeW'(cfg.bit_period_ps);

  assign off_neg = -offset_q;
  assign mag     = offset_q[OffsetW-1] ? off_neg[31:0] : offset_q[31:0];

  // Division of the Horner term by the step index, via a reciprocal product
  // and a single correction.
  assign q_est = prod[61:32];
  assign rem_w = 34'(d_q) - 34'(q_est) * 34'(i_q);
  assign quot  = (rem_w >= 34'(i_q)) ? q_est + 30'd1 : q_est;

  assign r_round = 32'(r_q) + (32'd1 << (29 - EXP_FRAC_BITS));

  // Settling: magnitude times exp, rounded half away from zero, then saturated.
  assign p_round   = prod + (MulPW'(1) << (EXP_FRAC_BITS - 1));
  assign qv        = 33'(p_round >> EXP_FRAC_BITS);
  assign level_raw = offset_q[OffsetW-1] ?
                     $signed({3'b000, target_cur}) - $signed({2'b00, qv}) :
                     $signed({3'b000, target_cur}) + $signed({2'b00, qv});

  always_comb begin
    if (level_raw[34]) begin
      level = 32'd0;
    end else if (level_raw[33:32] != 2'b00) begin
      level = 32'hFFFF_FFFF;
    end else begin
      level = level_raw[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    offset_d    = offset_q;
    cur_bit_d   = cur_bit_q;
    nbit_d      = nbit_q;
    first_d     = first_q;
    bnd_d       = bnd_q;
    u_d         = u_q;
    r_d         = r_q;
    d_d         = d_q;
    i_d         = i_q;
    sq_d        = sq_q;
    e_d         = e_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          t_d     = t_sat;
          nbit_d  = in_item_i.next_bit;
          first_d = 1'b1;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // The boundary pass uses the full period as its time argument.
        bnd_d   = first_q && crossed;
        first_d = 1'b0;
        mul_a   = (first_q && crossed) ? MulAW'(cfg.bit_period_ps) : t_q;
        mul_b   = MulBW'(rate_cur);
        state_d = ST_XCHK;
      end

      ST_XCHK: begin
        if (prod[MulPW-1:28] != '0) begin
          e_d     = '0;
          state_d = ST_SET_MUL;
        end else begin
          u_d     = {prod[27:0], 2'b00};
          r_d     = WorkOne;
          i_d     = HornerTerms;
          state_d = ST_H_MUL;
        end
      end

      ST_H_MUL: begin
        mul_a   = MulAW'(u_q);
        mul_b   = MulBW'(r_q);
        state_d = ST_H_DIV;
      end

      ST_H_DIV: begin
        d_d     = prod[59:30];
        mul_a   = MulAW'(prod[59:30]);
        mul_b   = recip_lookup(i_q);
        state_d = ST_H_FIX;
      end

      ST_H_FIX: begin
        r_d = WorkOne - WorkW'(quot);
        i_d = i_q - 4'd1;
        if (i_q == 4'd1) begin
          sq_d    = '0;
          state_d = ST_SQ_MUL;
        end else begin
          state_d = ST_H_MUL;
        end
      end

      ST_SQ_MUL: begin
        mul_a   = MulAW'(r_q);
        mul_b   = MulBW'(r_q);
        state_d = ST_SQ_RND;
      end

      ST_SQ_RND: begin
        r_d = prod[60:30] + WorkW'(prod[29]);
        if (sq_q == SquareLast) begin
          state_d = ST_EXP_RND;
        end else begin
          sq_d    = sq_q + 2'd1;
          state_d = ST_SQ_MUL;
        end
      end

      ST_EXP_RND: begin
        e_d     = EW'(r_round >> ShiftE);
        state_d = ST_SET_MUL;
      end

      ST_SET_MUL: begin
        mul_a   = MulAW'(mag);
        mul_b   = MulBW'(e_q);
        state_d = ST_SET_ADD;
      end

      ST_SET_ADD: begin
        // Keep the product steady while a previous result is still waiting.
        mul_a = MulAW'(mag);
        mul_b = MulBW'(e_q);
        if (bnd_q) begin
          // End of the outgoing bit: switch to the new bit and re-evaluate.
          offset_d  = $signed({1'b0, level}) - $signed({1'b0, target_new});
          cur_bit_d = nbit_q;
          t_d       = t_q - TimeW'(cfg.bit_period_ps);
          bnd_d     = 1'b0;
          state_d   = ST_CHECK;
        end else if (!out_valid_q || out_ready_i) begin
          out_item_d.power_nw = level;
          out_item_d.bit_now  = cur_bit_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q         <= '0;
      offset_q    <= '0;
      cur_bit_q   <= 1'b0;
      first_q     <= 1'b0;
      bnd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      t_q         <= t_d;
      offset_q    <= offset_d;
      cur_bit_q   <= cur_bit_d;
      first_q     <= first_d;
      bnd_q       <= bnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nbit_q     <= nbit_d;
    u_q        <= u_d;
    r_q        <= r_d;
    d_q        <= d_d;
    i_q        <= i_d;
    sq_q       <= sq_d;
    e_q        <= e_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The reciprocal estimate is never more than one below the true quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_H_FIX) |-> (rem_w < 34'({i_q, 1'b0})))
    else $error("Horner division estimate off by more than one");

  // The Horner term and the squared value stay within 0..1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_H_MUL || state_q == ST_SQ_MUL) |-> (r_q <= WorkOne))
    else $error("exponential working value above one");

  // An accepted transaction always starts a fresh boundary check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CHECK && first_q))
    else $error("accepted transaction did not start the sequencer");

  // A result appears only out of the final settling step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_SET_ADD && !$past(bnd_q)))
    else $error("result raised outside the final settling step");

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NRZ first-order edge waveform unit. Ticks flow
// through a random-gap driver, results are taken by a monitor with random
// back-pressure, and every result is compared against a bit-exact software
// copy of the edge model kept inside the bench. Register settings are changed
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfew_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned CycleLimit = 600_000;
  localparam longint unsigned Max32   = 64'hFFFF_FFFF;
  localparam longint unsigned TimeMax = (64'd1 << 33) - 1;
  localparam longint unsigned WorkUnit = 64'd1 << 30;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [31:0]         cfg_data_i  = '0;

  // Register copy and edge state of the bench's own waveform model.
  cfg_t regs = '{bit_period_ps: 32'd1000, zero_level_nw: 32'd0,
                 one_level_nw: 32'd1000000, zero_rate: 24'd16777,
                 one_rate: 24'd16777};
  longint unsigned wf_time_ps   = 0;
  longint          wf_offset_nw = 0;
  logic            wf_bit       = 1'b0;

  in_item_t    tick_q[$];
  out_item_t   power_expect_q[$];
  int unsigned ticks_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  bit          quiet_in      = 1'b0;
  bit          quiet_out     = 1'b0;
  bit          wild_steps    = 1'b0;

  nrz_first_order_edge_waveform_unit #(
    .EXP_FRAC_BITS(FracBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // exp(-x) for x in Q0.24, result in Q1.FracBits; zero once x reaches 16.
  function automatic longint unsigned exp_decay(longint unsigned x);
    longint unsigned u, r, k;
    if (x >= (64'd16 << 24)) begin
      return 0;
    end
    u = x << 2;
    r = WorkUnit;
    for (k = 12; k >= 1; k--) begin
      r = WorkUnit - ((u * r) >> 30) / k;
    end
    for (k = 0; k < 4; k++) begin
      r = (r * r + (64'd1 << 29)) >> 30;
    end
    return (r + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
  endfunction

  // target + offset * e, rounded on the magnitude, clamped to 32 bits.
  function automatic longint settle_level(longint unsigned target, longint offset,
                                          longint unsigned e);
    longint unsigned mag, q;
    longint v;
    if (offset < 0) begin
      mag = -offset;
    end else begin
      mag = offset;
    end
    q = (mag * e + (64'd1 << (FracBits - 1))) >> FracBits;
    if (offset < 0) begin
      v = longint'(target) - longint'(q);
    end else begin
      v = longint'(target) + longint'(q);
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > longint'(Max32)) begin
      v = longint'(Max32);
    end
    return v;
  endfunction

  function automatic out_item_t advance_waveform(in_item_t it);
    longint unsigned target, rate, period, t;
    longint level;
    out_item_t res;
    period = regs.bit_period_ps;
    target = wf_bit ? regs.one_level_nw : regs.zero_level_nw;
    rate   = wf_bit ? regs.one_rate : regs.zero_rate;
    t = wf_time_ps + longint'(it.step_time_ps);
    if (t > TimeMax) begin
      t = TimeMax;
    end
    // Only one period is retired per tick, however far the time has run.
    if (t >= period) begin
      level  = settle_level(target, wf_offset_nw, exp_decay(period * rate));
      wf_bit = it.next_bit;
      target = wf_bit ? regs.one_level_nw : regs.zero_level_nw;
      rate   = wf_bit ? regs.one_rate : regs.zero_rate;
      wf_offset_nw = level - longint'(target);
      t = t - period;
    end
    wf_time_ps = t;
    level = settle_level(target, wf_offset_nw, exp_decay(wf_time_ps * rate));
    res.power_nw = level[31:0];
    res.bit_now  = wf_bit;
    return res;
  endfunction

  function automatic int unsigned idle_len(bit quiet);
    int unsigned p;
    if (quiet) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end
    if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Steps are mostly scaled to the bit period so that bits are walked through
  // in pieces, with exact and multi-period crossings mixed in.
  function automatic in_item_t random_tick();
    in_item_t it;
    longint unsigned span, hi;
    int unsigned pick;
    span = (regs.bit_period_ps < 64) ? 64 : regs.bit_period_ps;
    pick = $urandom_range(0, 99);
    it.next_bit = 1'($urandom_range(0, 1));
    if (wild_steps) begin
      it.step_time_ps = (pick < 10) ? 32'hFFFF_FFFF : $urandom();
    end else if (pick < 8) begin
      it.step_time_ps = '0;
    end else if (pick < 60) begin
      it.step_time_ps = $urandom_range(0, 32'(span / 4));
    end else if (pick < 85) begin
      hi = span + 2;
      if (hi > Max32) begin
        hi = Max32;
      end
      it.step_time_ps = $urandom_range(32'(span - 2), 32'(hi));
    end else begin
      hi = span * 3;
      if (hi > Max32) begin
        hi = Max32;
      end
      it.step_time_ps = $urandom_range(0, 32'(hi));
    end
    return it;
  endfunction

  task automatic queue_tick(logic [31:0] step, logic nb);
    in_item_t it;
    it.step_time_ps = step;
    it.next_bit     = nb;
    tick_q.push_back(it);
    ticks_queued++;
  endtask

  task automatic drain();
    while (results_seen < ticks_queued) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_ticks(int unsigned n);
    repeat (n) begin
      tick_q.push_back(random_tick());
      ticks_queued++;
    end
    drain();
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BIT_PERIOD: regs.bit_period_ps = data;
      CFG_ZERO_LEVEL: regs.zero_level_nw = data;
      CFG_ONE_LEVEL:  regs.one_level_nw  = data;
      CFG_ZERO_RATE:  regs.zero_rate     = data[23:0];
      CFG_ONE_RATE:   regs.one_rate      = data[23:0];
      default: ;
    endcase
  endtask

  // Rates go out with junk in the upper byte, which the unit must drop.
  task automatic write_rate(logic [CfgIdxW-1:0] idx, logic [23:0] rate);
    logic [31:0] d;
    d = $urandom();
    d[23:0] = rate;
    write_reg(idx, d);
  endtask

  // Brings the time in bit back to zero by setting the period to it and
  // sending empty ticks, so that a phase starts at a bit boundary.
  task automatic rewind_bit_clock();
    while (wf_time_ps != 0) begin
      write_reg(CFG_BIT_PERIOD, (wf_time_ps > Max32) ? 32'hFFFF_FFFF : wf_time_ps[31:0]);
      queue_tick(32'd0, 1'($urandom_range(0, 1)));
      drain();
    end
  endtask

  function automatic logic [23:0] random_rate();
    return 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 20));
  endfunction

  // Tick driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        power_expect_q.push_back(advance_waveform(in_item_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (tick_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= tick_q.pop_front();
          send_gap   <= idle_len(quiet_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (power_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending: power_nw %0d bit_now %0d",
                   $time, out_item_o.power_nw, out_item_o.bit_now);
        end else begin
          want = power_expect_q.pop_front();
          if (out_item_o.power_nw !== want.power_nw) begin
            mismatches++;
            $display("%0t: power_nw expected %0d actual %0d", $time,
                     want.power_nw, out_item_o.power_nw);
          end
          if (out_item_o.bit_now !== want.bit_now) begin
            mismatches++;
            $display("%0t: bit_now expected %0d actual %0d", $time,
                     want.bit_now, out_item_o.bit_now);
          end
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= idle_len(quiet_out);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    longint unsigned period;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: exact boundaries, multi-period ticks and time saturation.
    queue_tick(32'd0, 1'b1);
    queue_tick(32'd400, 1'b1);
    queue_tick(32'd600, 1'b1);
    queue_tick(32'd1, 1'b0);
    queue_tick(32'd300, 1'b0);
    queue_tick(32'd699, 1'b0);
    queue_tick(32'd999, 1'b1);
    queue_tick(32'd1, 1'b1);
    queue_tick(32'd2000, 1'b0);
    queue_tick(32'd0, 1'b1);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'd0, 1'b1);
    queue_tick(32'h8000_0000, 1'b0);
    drain();
    rewind_bit_clock();

    // Ordinary link.
    write_reg(CFG_BIT_PERIOD, 32'd1000);
    write_reg(CFG_ZERO_LEVEL, 32'd20000);
    write_reg(CFG_ONE_LEVEL, 32'd3000000);
    write_rate(CFG_ZERO_RATE, 24'd40000);
    write_rate(CFG_ONE_RATE, 24'd9000);
    run_ticks(90);
    rewind_bit_clock();

    // Extremes: one-picosecond bits, inverted full-scale levels, fastest and
    // frozen edges.
    write_reg(CFG_BIT_PERIOD, 32'd1);
    write_reg(CFG_ZERO_LEVEL, 32'hFFFF_FFFF);
    write_reg(CFG_ONE_LEVEL, 32'd0);
    write_rate(CFG_ZERO_RATE, 24'hFF_FFFF);
    write_rate(CFG_ONE_RATE, 24'd0);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    run_ticks(80);
    rewind_bit_clock();

    // Longest bits with any step; writes to unused indexes must be ignored.
    for (int k = 1; k <= 3; k++) begin
      write_reg(CfgIdxW'(CFG_ONE_RATE) + CfgIdxW'(k), $urandom());
    end
    write_reg(CFG_BIT_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_ZERO_LEVEL, $urandom());
    write_reg(CFG_ONE_LEVEL, $urandom());
    write_rate(CFG_ZERO_RATE, 24'($urandom_range(0, 7)));
    write_rate(CFG_ONE_RATE, 24'($urandom_range(0, 7)));
    quiet_in   = 1'b0;
    quiet_out  = 1'b0;
    wild_steps = 1'b1;
    run_ticks(70);
    wild_steps = 1'b0;
    rewind_bit_clock();

    // Zero period: every tick switches bits and the time keeps growing.
    write_reg(CFG_BIT_PERIOD, 32'd0);
    write_rate(CFG_ZERO_RATE, 24'd30000);
    write_rate(CFG_ONE_RATE, 24'd70000);
    run_ticks(60);
    rewind_bit_clock();

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: period = $urandom_range(1, 5000);
        7, 8:                period = $urandom_range(1, 1 << 20);
        default:             period = $urandom();
      endcase
      write_reg(CFG_BIT_PERIOD, period[31:0]);
      write_reg(CFG_ZERO_LEVEL, $urandom());
      write_reg(CFG_ONE_LEVEL, $urandom());
      write_rate(CFG_ZERO_RATE, random_rate());
      write_rate(CFG_ONE_RATE, random_rate());
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      run_ticks(60);
      rewind_bit_clock();
    end

    drain();
    repeat (120) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
